// ===== sv/ptls_pkg.sv =====
// ----------------------------------------------------------------------------
// ptls_pkg
// Shared types, constants and saturation helpers for the two-view
// triangulation unit.
// ----------------------------------------------------------------------------
package ptls_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int MUL_LAT       = 4;
  localparam int FIFO_DEPTH    = 4;
  localparam int CFG_IDX_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_PAIR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_TRANS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_PAIR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_TRANS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_PAIR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_TRANS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DET_THR    = 3'd6;

  // register reset values
  localparam logic [63:0] RST_ROW0_PAIR  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] RST_ROW0_TRANS = 64'h0;
  localparam logic [63:0] RST_ROW1_PAIR  = 64'h0100_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_TRANS = 64'h0;
  localparam logic [63:0] RST_ROW2_PAIR  = 64'h0;
  localparam logic [63:0] RST_ROW2_TRANS = 64'h0000_0000_0100_0000;
  localparam logic [31:0] RST_DET_THR    = 32'd1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [47:0] VMAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] VMIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic signed [31:0] ref_u;
    logic signed [31:0] ref_v;
    logic signed [31:0] cur_u;
    logic signed [31:0] cur_v;
  } in_t;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic signed [47:0] point_z;
    logic [1:0]         status;
  } out_t;

  // rot is row major r00..r22
  typedef struct packed {
    logic [8:0][31:0] rot;
    logic [2:0][31:0] trans;
    logic [31:0]      thr;
  } pose_t;

  typedef struct packed {
    logic               sat;
    logic signed [47:0] v;
  } sv_t;

  // word handed from front to back
  typedef struct packed {
    logic signed [31:0] ru;
    logic signed [31:0] rv;
    logic signed [47:0] num;
    logic signed [47:0] det;
    logic               degen;
    logic               sat;
  } work_t;

  function automatic logic signed [47:0] sx48(input logic [31:0] x);
    sx48 = {{16{x[31]}}, x};
  endfunction

  // clamp a grown sum back to 48 bits
  function automatic sv_t sat50(input logic signed [49:0] x);
    sv_t r;
    if (x[49:47] == 3'b000 || x[49:47] == 3'b111) begin
      r.sat = 1'b0;
      r.v   = x[47:0];
    end else begin
      r.sat = 1'b1;
      r.v   = x[49] ? VMIN : VMAX;
    end
    sat50 = r;
  endfunction

  function automatic sv_t neg48(input logic signed [47:0] x);
    sv_t r;
    if (x == VMIN) begin
      r.sat = 1'b1;
      r.v   = VMAX;
    end else begin
      r.sat = 1'b0;
      r.v   = -x;
    end
    neg48 = r;
  endfunction

endpackage

// ===== sv/pose_triangulate_least_squares_unit.sv =====
// ----------------------------------------------------------------------------
// pose_triangulate_least_squares_unit
// Two-view linear triangulation of point correspondences against a
// programmed pose, in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one correspondence per clock while busy is low and returns one
// result per correspondence, in order, as a one-cycle done_o strobe that the
// receiver cannot stall. A correspondence passes the front-end multiply and
// sum stages and a classify register, the queue, a divider load register,
// the bit-per-stage divider, a rounding stage, 4 multiply stages and the
// output register. Every back-end stage takes a new word each cycle, so the
// back end drains the queue as fast as the front end fills it and busy stays
// low.
// Program the pose and threshold only while no correspondence is in flight.
module pose_triangulate_least_squares_unit #(
  parameter int FRAC_BITS = ptls_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  ptls_pkg::in_t                      in_i,
  output logic                               done_o,
  output ptls_pkg::out_t                     res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [63:0]                        cfg_data_i
);
  import ptls_pkg::*;

  logic [63:0] pair_q [3];
  logic [63:0] trans_q [3];
  logic [31:0] thr_q;
  pose_t       pose;
  logic        full, push, empty, acc;
  work_t       fr_word, bk_word;

  // write pose registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q[0]  <= RST_ROW0_PAIR;
      trans_q[0] <= RST_ROW0_TRANS;
      pair_q[1]  <= RST_ROW1_PAIR;
      trans_q[1] <= RST_ROW1_TRANS;
      pair_q[2]  <= RST_ROW2_PAIR;
      trans_q[2] <= RST_ROW2_TRANS;
      thr_q      <= RST_DET_THR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW0_PAIR:  pair_q[0]  <= cfg_data_i;
        REG_ROW0_TRANS: trans_q[0] <= cfg_data_i;
        REG_ROW1_PAIR:  pair_q[1]  <= cfg_data_i;
        REG_ROW1_TRANS: trans_q[1] <= cfg_data_i;
        REG_ROW2_PAIR:  pair_q[2]  <= cfg_data_i;
        REG_ROW2_TRANS: trans_q[2] <= cfg_data_i;
        REG_DET_THR:    thr_q      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // unpack rows into matrix and vector
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pose.rot[3*k]     = pair_q[k][31:0];
      pose.rot[3*k + 1] = pair_q[k][63:32];
      pose.rot[3*k + 2] = trans_q[k][31:0];
      pose.trans[k]     = trans_q[k][63:32];
    end
    pose.thr = thr_q;
  end

  assign busy = full;
  assign acc  = start && !full;

  ptls_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .in_i   (in_i),
    .pose_i (pose),
    .full_i (full),
    .push_o (push),
    .work_o (fr_word)
  );

  ptls_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_word),
    .full_o  (full),
    .pop_i   (!empty),
    .empty_o (empty),
    .data_o  (bk_word)
  );

  ptls_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (!empty),
    .work_i (bk_word),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ===== sv/ptls_mul.sv =====
// ----------------------------------------------------------------------------
// ptls_mul
// Four-stage fixed point multiplier: 48x48 magnitude product from 24x24
// partial products, rounded half away from zero and saturated to 48 bits.
// ----------------------------------------------------------------------------
module ptls_mul #(
  parameter int FRAC_BITS = ptls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [47:0] a_i,
  input  logic signed [47:0] b_i,
  output logic signed [47:0] p_o,
  output logic               sat_o
);
  import ptls_pkg::*;

  localparam logic [96:0] RND = 97'(1) << (FRAC_BITS - 1);

  logic        neg_a_q, neg_b_q, neg_c_q;
  logic [47:0] ma_q, mb_q;
  logic [47:0] hh_q, hl_q, lh_q, ll_q;
  logic [96:0] sum_q;
  logic [96:0] shf;
  logic [47:0] lim;
  logic [47:0] mag;
  logic        ovf;
  logic signed [47:0] p_q;
  logic        sat_q;

  // take magnitudes and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= a_i[47] ^ b_i[47];
      ma_q    <= a_i[47] ? (~a_i + 48'd1) : a_i;
      mb_q    <= b_i[47] ? (~b_i + 48'd1) : b_i;
    end
  end

  // form partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_b_q <= neg_a_q;
      hh_q    <= ma_q[47:24] * mb_q[47:24];
      hl_q    <= ma_q[47:24] * mb_q[23:0];
      lh_q    <= ma_q[23:0] * mb_q[47:24];
      ll_q    <= ma_q[23:0] * mb_q[23:0];
    end
  end

  // sum partials with rounding constant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_c_q <= neg_b_q;
      sum_q   <= {1'b0, hh_q, 48'b0} + ((97'(hl_q) + 97'(lh_q)) << 24) + 97'(ll_q) + RND;
    end
  end

  // scale, clamp, restore sign
  always_comb begin
    shf = sum_q >> FRAC_BITS;
    lim = neg_c_q ? VMIN : VMAX;
    ovf = shf > 97'(lim);
    mag = ovf ? lim : shf[47:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= neg_c_q ? -mag : mag;
      sat_q <= ovf;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat_q;

endmodule

// ===== sv/ptls_fifo.sv =====
// ----------------------------------------------------------------------------
// ptls_fifo
// Short queue between the front end and the solver back end.
// ----------------------------------------------------------------------------
module ptls_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptls_pkg::work_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ptls_pkg::work_t data_o
);
  import ptls_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  work_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // store word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  assign full_o  = cnt_q == CW'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

endmodule

// ===== sv/ptls_front.sv =====
// ----------------------------------------------------------------------------
// ptls_front
// Front end: builds the normal equations, forms determinant and numerator,
// and classifies each correspondence as degenerate or solvable.
// ----------------------------------------------------------------------------
module ptls_front #(
  parameter int FRAC_BITS = ptls_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  ptls_pkg::in_t   in_i,
  input  ptls_pkg::pose_t pose_i,
  input  logic            full_i,
  output logic            push_o,
  output ptls_pkg::work_t work_o
);
  import ptls_pkg::*;

  localparam logic signed [49:0] ONE = 50'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv, cu, cv;
  } s1_t;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv, cu, cv;
    logic signed [2:0][47:0] a2;
    logic sat;
  } st1_t;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv;
    logic signed [47:0] a22;
    logic sat;
  } s2_t;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv;
    logic signed [47:0] s00, s01, s11, b0, b1;
    logic sat;
  } st2_t;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv;
    logic sat;
  } s3_t;

  typedef struct packed {
    logic v;
    logic signed [31:0] ru, rv;
    logic signed [47:0] det, num;
    logic sat;
  } st3_t;

  logic en;
  assign en = !full_i;

  s1_t  d1_q [MUL_LAT];
  st1_t st1_q, st1_d;
  s2_t  d2_q [MUL_LAT];
  st2_t st2_q, st2_d;
  s3_t  d3_q [MUL_LAT];
  st3_t st3_q, st3_d;
  work_t work_q;
  logic  vld_q;

  logic signed [47:0] g1_p [6];
  logic               g1_s [6];
  logic signed [47:0] g2_a [12];
  logic signed [47:0] g2_b [12];
  logic signed [47:0] g2_p [12];
  logic               g2_s [12];
  logic signed [47:0] g3_a [4];
  logic signed [47:0] g3_b [4];
  logic signed [47:0] g3_p [4];
  logic               g3_s [4];

  // rotate the reference ray: r[j][0]*ru and r[j][1]*rv
  for (genvar k = 0; k < 6; k++) begin : g_m1
    ptls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (sx48(pose_i.rot[3*(k/2) + (k%2)])),
      .b_i   ((k % 2 == 0) ? sx48(in_i.ref_u) : sx48(in_i.ref_v)),
      .p_o   (g1_p[k]),
      .sat_o (g1_s[k])
    );
  end

  // delay side data alongside the first multiply group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_LAT; i++) d1_q[i] <= '0;
    end else if (en) begin
      d1_q[0] <= '{acc_i, in_i.ref_u, in_i.ref_v, in_i.cur_u, in_i.cur_v};
      for (int i = 1; i < MUL_LAT; i++) d1_q[i] <= d1_q[i-1];
    end
  end

  // second column of A: a2 = -(R*qr)
  always_comb begin
    sv_t s, n;
    st1_d.v   = d1_q[MUL_LAT-1].v;
    st1_d.ru  = d1_q[MUL_LAT-1].ru;
    st1_d.rv  = d1_q[MUL_LAT-1].rv;
    st1_d.cu  = d1_q[MUL_LAT-1].cu;
    st1_d.cv  = d1_q[MUL_LAT-1].cv;
    st1_d.sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s = sat50(50'(g1_p[2*j]) + 50'(g1_p[2*j+1]) + 50'(sx48(pose_i.rot[3*j+2])));
      n = neg48(s.v);
      st1_d.a2[j] = n.v;
      st1_d.sat   = st1_d.sat | s.sat | n.sat | g1_s[2*j] | g1_s[2*j+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st1_q <= '0;
    else if (en) st1_q <= st1_d;
  end

  // operands of the normal equation products
  always_comb begin
    logic signed [47:0] cu, cv;
    cu = sx48(st1_q.cu);
    cv = sx48(st1_q.cv);
    g2_a[0]  = cu;          g2_b[0]  = cu;
    g2_a[1]  = cv;          g2_b[1]  = cv;
    g2_a[2]  = cu;          g2_b[2]  = st1_q.a2[0];
    g2_a[3]  = cv;          g2_b[3]  = st1_q.a2[1];
    g2_a[4]  = st1_q.a2[0]; g2_b[4]  = st1_q.a2[0];
    g2_a[5]  = st1_q.a2[1]; g2_b[5]  = st1_q.a2[1];
    g2_a[6]  = st1_q.a2[2]; g2_b[6]  = st1_q.a2[2];
    g2_a[7]  = cu;          g2_b[7]  = sx48(pose_i.trans[0]);
    g2_a[8]  = cv;          g2_b[8]  = sx48(pose_i.trans[1]);
    g2_a[9]  = st1_q.a2[0]; g2_b[9]  = sx48(pose_i.trans[0]);
    g2_a[10] = st1_q.a2[1]; g2_b[10] = sx48(pose_i.trans[1]);
    g2_a[11] = st1_q.a2[2]; g2_b[11] = sx48(pose_i.trans[2]);
  end

  for (genvar k = 0; k < 12; k++) begin : g_m2
    ptls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (g2_a[k]),
      .b_i   (g2_b[k]),
      .p_o   (g2_p[k]),
      .sat_o (g2_s[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_LAT; i++) d2_q[i] <= '0;
    end else if (en) begin
      d2_q[0] <= '{st1_q.v, st1_q.ru, st1_q.rv, st1_q.a2[2], st1_q.sat};
      for (int i = 1; i < MUL_LAT; i++) d2_q[i] <= d2_q[i-1];
    end
  end

  // accumulate AtA and Att
  always_comb begin
    sv_t s00, s01, s11, b0, b1;
    logic any;
    s00 = sat50(50'(g2_p[0]) + 50'(g2_p[1]) + ONE);
    s01 = sat50(50'(g2_p[2]) + 50'(g2_p[3]) + 50'(d2_q[MUL_LAT-1].a22));
    s11 = sat50(50'(g2_p[4]) + 50'(g2_p[5]) + 50'(g2_p[6]));
    b0  = sat50(50'(g2_p[7]) + 50'(g2_p[8]) + 50'(sx48(pose_i.trans[2])));
    b1  = sat50(50'(g2_p[9]) + 50'(g2_p[10]) + 50'(g2_p[11]));
    any = 1'b0;
    for (int k = 0; k < 12; k++) any = any | g2_s[k];
    st2_d.v   = d2_q[MUL_LAT-1].v;
    st2_d.ru  = d2_q[MUL_LAT-1].ru;
    st2_d.rv  = d2_q[MUL_LAT-1].rv;
    st2_d.s00 = s00.v;
    st2_d.s01 = s01.v;
    st2_d.s11 = s11.v;
    st2_d.b0  = b0.v;
    st2_d.b1  = b1.v;
    st2_d.sat = d2_q[MUL_LAT-1].sat | any | s00.sat | s01.sat | s11.sat | b0.sat | b1.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st2_q <= '0;
    else if (en) st2_q <= st2_d;
  end

  // Cramer products
  always_comb begin
    g3_a[0] = st2_q.s00; g3_b[0] = st2_q.s11;
    g3_a[1] = st2_q.s01; g3_b[1] = st2_q.s01;
    g3_a[2] = st2_q.s00; g3_b[2] = st2_q.b1;
    g3_a[3] = st2_q.s01; g3_b[3] = st2_q.b0;
  end

  for (genvar k = 0; k < 4; k++) begin : g_m3
    ptls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (g3_a[k]),
      .b_i   (g3_b[k]),
      .p_o   (g3_p[k]),
      .sat_o (g3_s[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_LAT; i++) d3_q[i] <= '0;
    end else if (en) begin
      d3_q[0] <= '{st2_q.v, st2_q.ru, st2_q.rv, st2_q.sat};
      for (int i = 1; i < MUL_LAT; i++) d3_q[i] <= d3_q[i-1];
    end
  end

  // determinant and numerator
  always_comb begin
    sv_t det, num;
    det = sat50(50'(g3_p[0]) - 50'(g3_p[1]));
    num = sat50(50'(g3_p[2]) - 50'(g3_p[3]));
    st3_d.v   = d3_q[MUL_LAT-1].v;
    st3_d.ru  = d3_q[MUL_LAT-1].ru;
    st3_d.rv  = d3_q[MUL_LAT-1].rv;
    st3_d.det = det.v;
    st3_d.num = num.v;
    st3_d.sat = d3_q[MUL_LAT-1].sat | g3_s[0] | g3_s[1] | g3_s[2] | g3_s[3]
                | det.sat | num.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st3_q <= '0;
    else if (en) st3_q <= st3_d;
  end

  // classify against the determinant threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= st3_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [47:0] dmag;
    dmag = st3_q.det[47] ? (~st3_q.det + 48'd1) : st3_q.det;
    if (en) begin
      work_q.ru    <= st3_q.ru;
      work_q.rv    <= st3_q.rv;
      work_q.num   <= st3_q.num;
      work_q.det   <= st3_q.det;
      work_q.degen <= (st3_q.det == '0) || (dmag < {16'b0, pose_i.thr});
      work_q.sat   <= st3_q.sat;
    end
  end

  assign push_o = vld_q && !full_i;
  assign work_o = work_q;

endmodule

// ===== sv/ptls_back.sv =====
// ----------------------------------------------------------------------------
// ptls_back
// Back end: pipelined restoring divider for the reference depth, then the
// scaling of the reference ray and the final status.
// ----------------------------------------------------------------------------
module ptls_back #(
  parameter int FRAC_BITS = ptls_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  ptls_pkg::work_t work_i,
  output logic            done_o,
  output ptls_pkg::out_t  res_o
);
  import ptls_pkg::*;

  localparam int N  = 48 + FRAC_BITS;
  localparam int QW = 48 + FRAC_BITS;

  typedef struct packed {
    logic        neg;
    logic [47:0] un, ud, rem;
    logic [QW-1:0] q;
    logic signed [31:0] ru, rv;
    logic        degen, sat;
  } div_t;

  typedef struct packed {
    logic v;
    logic signed [47:0] zr;
    logic signed [31:0] ru, rv;
    logic degen, sat;
  } zs_t;

  typedef struct packed {
    logic v;
    logic signed [47:0] zr;
    logic degen, sat;
  } dz_t;

  div_t   dv_q [N+1];
  logic [N:0] dv_v_q;
  zs_t    zs_q, zs_d;
  dz_t    dz_q [MUL_LAT];
  logic signed [47:0] px, py;
  logic   px_s, py_s;
  logic   done_q;
  out_t   res_q;

  // load divider from the queue
  always_ff @(posedge clk_i) begin
    dv_q[0].neg   <= work_i.num[47] ^ work_i.det[47];
    dv_q[0].un    <= work_i.num[47] ? (~work_i.num + 48'd1) : work_i.num;
    dv_q[0].ud    <= work_i.det[47] ? (~work_i.det + 48'd1) : work_i.det;
    dv_q[0].rem   <= '0;
    dv_q[0].q     <= '0;
    dv_q[0].ru    <= work_i.ru;
    dv_q[0].rv    <= work_i.rv;
    dv_q[0].degen <= work_i.degen;
    dv_q[0].sat   <= work_i.sat;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_div
    div_t nx;
    always_comb begin
      logic [48:0] r;
      logic        qb;
      r  = {dv_q[k].rem, dv_q[k].un[47]};
      nx = dv_q[k];
      nx.un = dv_q[k].un << 1;
      if (r >= {1'b0, dv_q[k].ud}) begin
        nx.rem = 48'(r - {1'b0, dv_q[k].ud});
        qb = 1'b1;
      end else begin
        nx.rem = r[47:0];
        qb = 1'b0;
      end
      nx.q = {dv_q[k].q[QW-2:0], qb};
    end
    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q <= '0;
    else dv_v_q <= {dv_v_q[N-1:0], vld_i};
  end

  // round quotient and clamp the depth
  always_comb begin
    logic        over, rnd, big;
    logic [48:0] qr;
    logic [47:0] lim, m;
    over = dv_q[N].q > (QW'(1) << 48);
    rnd  = {dv_q[N].rem, 1'b0} >= {1'b0, dv_q[N].ud};
    qr   = 49'(dv_q[N].q) + 49'(rnd);
    lim  = dv_q[N].neg ? VMIN : VMAX;
    big  = qr > 49'(lim);
    m    = big ? lim : qr[47:0];
    zs_d.v     = dv_v_q[N];
    zs_d.ru    = dv_q[N].ru;
    zs_d.rv    = dv_q[N].rv;
    zs_d.degen = dv_q[N].degen;
    if (over) begin
      zs_d.zr  = dv_q[N].neg ? VMIN : VMAX;
      zs_d.sat = 1'b1;
    end else begin
      zs_d.zr  = dv_q[N].neg ? -m : m;
      zs_d.sat = dv_q[N].sat | big;
    end
    if (over) zs_d.sat = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zs_q <= '0;
    else zs_q <= zs_d;
  end

  // scale the reference ray by the depth
  ptls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .a_i   (sx48(zs_q.ru)),
    .b_i   (zs_q.zr),
    .p_o   (px),
    .sat_o (px_s)
  );

  ptls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .a_i   (sx48(zs_q.rv)),
    .b_i   (zs_q.zr),
    .p_o   (py),
    .sat_o (py_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_LAT; i++) dz_q[i] <= '0;
    end else begin
      dz_q[0] <= '{zs_q.v, zs_q.zr, zs_q.degen, zs_q.sat};
      for (int i = 1; i < MUL_LAT; i++) dz_q[i] <= dz_q[i-1];
    end
  end

  // drive the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= dz_q[MUL_LAT-1].v;
  end

  always_ff @(posedge clk_i) begin
    if (dz_q[MUL_LAT-1].degen) begin
      res_q.point_x <= '0;
      res_q.point_y <= '0;
      res_q.point_z <= '0;
      res_q.status  <= ST_DEGEN;
    end else begin
      res_q.point_x <= px;
      res_q.point_y <= py;
      res_q.point_z <= dz_q[MUL_LAT-1].zr;
      res_q.status  <= (dz_q[MUL_LAT-1].sat | px_s | py_s) ? ST_SAT : ST_OK;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
